// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define PTN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication on top of the clocked form
`define PTN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `PTN_ASSERT(lbl, clk, rst_n, ((ante) |-> (cons)), msg)

`endif

// ===== sv/ptn_pkg.sv =====
`default_nettype none
package ptn_pkg;

  localparam int REGION_W = 3;
  localparam int DIST_W   = 34;

  // region codes of the (s,t) plane
  localparam logic [REGION_W-1:0] RGN_INTERIOR = 3'd0;
  localparam logic [REGION_W-1:0] RGN_HYP      = 3'd1;
  localparam logic [REGION_W-1:0] RGN_HYP_S0   = 3'd2;
  localparam logic [REGION_W-1:0] RGN_S0       = 3'd3;
  localparam logic [REGION_W-1:0] RGN_CORNER0  = 3'd4;
  localparam logic [REGION_W-1:0] RGN_T0       = 3'd5;
  localparam logic [REGION_W-1:0] RGN_HYP_T0   = 3'd6;
  localparam logic [REGION_W-1:0] RGN_DEGEN    = 3'd7;

  // quotient source for each divider
  localparam int SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_ZERO = 3'd0;
  localparam logic [SEL_W-1:0] SEL_ONE  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_TRI  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_EDGE = 3'd3;
  localparam logic [SEL_W-1:0] SEL_AXIS = 3'd4;

  // weight taken as the quotient or as one minus the other quotient
  localparam logic MODE_QUOT = 1'b0;
  localparam logic MODE_COMP = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage
`default_nettype wire

// ===== sv/ptn_dly.sv =====
`default_nettype none
module ptn_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule
`default_nettype wire

// ===== sv/ptn_mul.sv =====
`default_nettype none
module ptn_mul #(
  parameter int AW = 36,
  parameter int BW = 36
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int L  = BW / 2;
  localparam int H  = BW - L;
  localparam int PW = AW + BW;

  logic signed [AW+L:0]   pl_r, pl_nxt;
  logic signed [AW+H-1:0] ph_r, ph_nxt;
  logic signed [PW-1:0]   p_r, p_nxt;

  // low half unsigned, high half signed
  always_comb begin
    pl_nxt = a * $signed({1'b0, b[L-1:0]});
    ph_nxt = a * $signed(b[BW-1:L]);
    p_nxt  = (PW'(ph_r) <<< L) + PW'(pl_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== sv/ptn_div.sv =====
`default_nettype none
module ptn_div #(
  parameter int NW = 73,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [NW-1:0] den,
  output logic [FB:0]               q
);

  localparam int UW = NW - 1;

  logic [UW-1:0] rem_r  [FB+1];
  logic [UW-1:0] den_r  [FB+1];
  logic [FB-1:0] qb_r   [FB+1];
  logic          zero_r [FB+1];
  logic          one_r  [FB+1];

  logic zero_nxt, one_nxt;

  // clamp checks ahead of the bit steps
  always_comb begin
    zero_nxt = (num <= 0) || (den <= 0);
    one_nxt  = !zero_nxt && (num >= den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num[UW-1:0];
      den_r[0]  <= den[UW-1:0];
      qb_r[0]   <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= one_nxt;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [UW:0]   rem2;
    logic          ge;
    logic [UW-1:0] rem_nxt;
    always_comb begin
      rem2    = {rem_r[k-1], 1'b0};
      ge      = rem2 >= {1'b0, den_r[k-1]};
      rem_nxt = ge ? UW'(rem2 - {1'b0, den_r[k-1]}) : rem2[UW-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_r[k-1];
        qb_r[k]   <= {qb_r[k-1][FB-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  always_comb begin
    if (zero_r[FB]) begin
      q = '0;
    end else if (one_r[FB]) begin
      q = {1'b1, {FB{1'b0}}};
    end else begin
      q = {1'b0, qb_r[FB]};
    end
  end

endmodule
`default_nettype wire

// ===== sv/point_triangle_nearest.sv =====
// channel | ports                              | beat
// in      | in_valid / in_ready               | query point and three vertices
// out     | out_valid / out_ready             | weights, squared distance, region
//
// one beat accepted per cycle unless the output register is full and not taken
// the two dividers produce one quotient bit per stage
// rst_n (synchronous) clears only the valid bits of the pipeline
// the whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage and loses or repeats nothing
`default_nettype none
module point_triangle_nearest #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_query_x,
  input  wire logic signed [COORD_BITS-1:0] in_query_y,
  input  wire logic signed [COORD_BITS-1:0] in_query_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert0_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert0_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert0_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert1_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert1_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert1_z,
  input  wire logic signed [COORD_BITS-1:0] in_vert2_x,
  input  wire logic signed [COORD_BITS-1:0] in_vert2_y,
  input  wire logic signed [COORD_BITS-1:0] in_vert2_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [FRAC_BITS:0]                out_weight_s,
  output logic [FRAC_BITS:0]                out_weight_t,
  output logic [ptn_pkg::DIST_W-1:0]        out_dist_squared,
  output logic [ptn_pkg::REGION_W-1:0]      out_region_code
);

  localparam int CW   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int DFW  = CW + 1;          // coordinate differences
  localparam int PRW  = 2 * DFW;         // per-axis products
  localparam int DW   = PRW + 2;         // dot products a..f
  localparam int MW   = 2 * DW;          // products of dot products
  localparam int NW   = MW + 1;          // det, sn, tn and all quotient operands
  localparam int SW2  = NW + 2;
  localparam int KW   = DW + 2;          // small sums of dot products
  localparam int WW   = FB + 1;          // weights
  localparam int SQW  = 2 * WW;          // weight products
  localparam int SPW  = SQW + 1;
  localparam int MPW  = DW + SPW;
  localparam int LNW  = DW + WW + 1;     // d*s, e*t
  localparam int LSW  = LNW + 1;
  localparam int ACW  = DW + 2 * WW + 4; // quadratic form accumulator
  localparam int HW   = ACW - 2 * FB;
  localparam int CMPW = (HW > ptn_pkg::DIST_W) ? HW : ptn_pkg::DIST_W;
  localparam int LAT  = FB + 16;
  localparam logic [WW-1:0] ONE_W = {1'b1, {FB{1'b0}}};

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: edge vectors and vertex-to-query vector
  logic signed [CW-1:0]  qv [3];
  logic signed [CW-1:0]  v0 [3];
  logic signed [CW-1:0]  v1 [3];
  logic signed [CW-1:0]  v2 [3];
  logic signed [DFW-1:0] bp_r [3];
  logic signed [DFW-1:0] e0_r [3];
  logic signed [DFW-1:0] e1_r [3];
  logic signed [DFW-1:0] bp_nxt [3];
  logic signed [DFW-1:0] e0_nxt [3];
  logic signed [DFW-1:0] e1_nxt [3];

  assign qv[0] = in_query_x;
  assign qv[1] = in_query_y;
  assign qv[2] = in_query_z;
  assign v0[0] = in_vert0_x;
  assign v0[1] = in_vert0_y;
  assign v0[2] = in_vert0_z;
  assign v1[0] = in_vert1_x;
  assign v1[1] = in_vert1_y;
  assign v1[2] = in_vert1_z;
  assign v2[0] = in_vert2_x;
  assign v2[1] = in_vert2_y;
  assign v2[2] = in_vert2_z;

  // stage 2: per-axis products
  logic signed [PRW-1:0] pa_r [3];
  logic signed [PRW-1:0] pb_r [3];
  logic signed [PRW-1:0] pc_r [3];
  logic signed [PRW-1:0] pd_r [3];
  logic signed [PRW-1:0] pe_r [3];
  logic signed [PRW-1:0] pf_r [3];
  logic signed [PRW-1:0] pa_nxt [3];
  logic signed [PRW-1:0] pb_nxt [3];
  logic signed [PRW-1:0] pc_nxt [3];
  logic signed [PRW-1:0] pd_nxt [3];
  logic signed [PRW-1:0] pe_nxt [3];
  logic signed [PRW-1:0] pf_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bp_nxt[i] = DFW'(v0[i]) - DFW'(qv[i]);
      e0_nxt[i] = DFW'(v1[i]) - DFW'(v0[i]);
      e1_nxt[i] = DFW'(v2[i]) - DFW'(v0[i]);
      pa_nxt[i] = e0_r[i] * e0_r[i];
      pb_nxt[i] = e0_r[i] * e1_r[i];
      pc_nxt[i] = e1_r[i] * e1_r[i];
      pd_nxt[i] = e0_r[i] * bp_r[i];
      pe_nxt[i] = e1_r[i] * bp_r[i];
      pf_nxt[i] = bp_r[i] * bp_r[i];
    end
  end

  // stage 3: dot products a..f
  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r, f_r;
  logic signed [DW-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt;

  always_comb begin
    a_nxt = DW'(pa_r[0]) + DW'(pa_r[1]) + DW'(pa_r[2]);
    b_nxt = DW'(pb_r[0]) + DW'(pb_r[1]) + DW'(pb_r[2]);
    c_nxt = DW'(pc_r[0]) + DW'(pc_r[1]) + DW'(pc_r[2]);
    d_nxt = DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
    e_nxt = DW'(pe_r[0]) + DW'(pe_r[1]) + DW'(pe_r[2]);
    f_nxt = DW'(pf_r[0]) + DW'(pf_r[1]) + DW'(pf_r[2]);
  end

  // stages 4-5: cross products for det, sn, tn
  logic signed [MW-1:0] ac_p, bb_p, be_p, cd_p, bd_p, ae_p;

  ptn_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk, .en(adv), .a(a_r), .b(c_r), .p(ac_p));
  ptn_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk, .en(adv), .a(b_r), .b(b_r), .p(bb_p));
  ptn_mul #(.AW(DW), .BW(DW)) u_mul_be (.clk, .en(adv), .a(b_r), .b(e_r), .p(be_p));
  ptn_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk, .en(adv), .a(c_r), .b(d_r), .p(cd_p));
  ptn_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clk, .en(adv), .a(b_r), .b(d_r), .p(bd_p));
  ptn_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clk, .en(adv), .a(a_r), .b(e_r), .p(ae_p));

  // stage 4 side: edge numerators and denominators, negated d and e
  logic signed [KW-1:0] k1_r, k2_r, k3_r, ce_r, ad_r, nd_r, ne_r;
  logic signed [KW-1:0] k1_nxt, k2_nxt, k3_nxt, ce_nxt, ad_nxt, nd_nxt, ne_nxt;
  logic                 agc_r, agc_nxt;

  always_comb begin
    k1_nxt  = KW'(c_r) + KW'(e_r) - KW'(b_r) - KW'(d_r);
    k2_nxt  = KW'(a_r) - (KW'(b_r) <<< 1) + KW'(c_r);
    k3_nxt  = KW'(a_r) + KW'(d_r) - KW'(b_r) - KW'(e_r);
    ce_nxt  = KW'(c_r) + KW'(e_r);
    ad_nxt  = KW'(a_r) + KW'(d_r);
    nd_nxt  = -(KW'(d_r));
    ne_nxt  = -(KW'(e_r));
    agc_nxt = a_r > c_r;
  end

  localparam int KPW = 7 * KW + 1;
  logic [KPW-1:0] kd_out;
  logic signed [KW-1:0] k1_6, k2_6, k3_6, ce_6, ad_6, nd_6, ne_6;
  logic                 agc_6;

  ptn_dly #(.W(KPW), .N(2)) u_dly_k (
    .clk, .en(adv),
    .d({k1_r, k2_r, k3_r, ce_r, ad_r, nd_r, ne_r, agc_r}),
    .q(kd_out)
  );
  assign {k1_6, k2_6, k3_6, ce_6, ad_6, nd_6, ne_6, agc_6} = kd_out;

  localparam int APW = 6 * DW;
  logic [APW-1:0] abc6_out, abc10_out;
  logic signed [DW-1:0] a6, b6, c6, d6;

  ptn_dly #(.W(APW), .N(3)) u_dly_dot0 (
    .clk, .en(adv), .d({a_r, b_r, c_r, d_r, e_r, f_r}), .q(abc6_out)
  );
  assign {a6, b6, c6, d6} = abc6_out[APW-1:2*DW];

  // stage 6: det and the unscaled s, t numerators
  logic signed [NW-1:0] det_r, sn_r, tn_r, det_nxt, sn_nxt, tn_nxt;

  always_comb begin
    det_nxt = NW'(ac_p) - NW'(bb_p);
    sn_nxt  = NW'(be_p) - NW'(cd_p);
    tn_nxt  = NW'(bd_p) - NW'(ae_p);
  end

  // stage 7: region classification and quotient sources
  logic signed [SW2-1:0] stsum;
  logic det_zero, sneg, tneg, sum_le;
  logic k1_pos, k3_pos, ce_le0, ad_le0, d_neg, b_pos, a_zero, c_zero;
  logic [ptn_pkg::REGION_W-1:0] region_nxt, region_r;
  logic [ptn_pkg::SEL_W-1:0]    sel0_nxt, sel1_nxt, sel0_r, sel1_r;
  logic                         sm_nxt, tm_nxt, sm_r, tm_r;

  always_comb begin
    stsum    = SW2'(sn_r) + SW2'(tn_r) - SW2'(det_r);
    sum_le   = stsum[SW2-1] || (stsum == '0);
    det_zero = det_r == '0;
    sneg     = sn_r[NW-1];
    tneg     = tn_r[NW-1];
    k1_pos   = !k1_6[KW-1] && (k1_6 != '0);
    k3_pos   = !k3_6[KW-1] && (k3_6 != '0);
    ce_le0   = ce_6[KW-1] || (ce_6 == '0);
    ad_le0   = ad_6[KW-1] || (ad_6 == '0);
    d_neg    = d6[DW-1];
    b_pos    = !b6[DW-1] && (b6 != '0);
    a_zero   = a6 == '0;
    c_zero   = c6 == '0;

    sel0_nxt = ptn_pkg::SEL_ZERO;
    sel1_nxt = ptn_pkg::SEL_ZERO;
    sm_nxt   = ptn_pkg::MODE_QUOT;
    tm_nxt   = ptn_pkg::MODE_QUOT;

    if (det_zero) begin
      region_nxt = ptn_pkg::RGN_DEGEN;
    end else if (!sum_le) begin
      region_nxt = sneg ? ptn_pkg::RGN_HYP_S0 : (tneg ? ptn_pkg::RGN_HYP_T0 : ptn_pkg::RGN_HYP);
    end else begin
      region_nxt = sneg ? (tneg ? ptn_pkg::RGN_CORNER0 : ptn_pkg::RGN_S0)
                        : (tneg ? ptn_pkg::RGN_T0 : ptn_pkg::RGN_INTERIOR);
    end

    unique case (region_nxt)
      ptn_pkg::RGN_INTERIOR: begin
        sel0_nxt = ptn_pkg::SEL_TRI;
        sel1_nxt = ptn_pkg::SEL_TRI;
      end
      ptn_pkg::RGN_HYP: begin
        sel0_nxt = ptn_pkg::SEL_EDGE;
        tm_nxt   = ptn_pkg::MODE_COMP;
      end
      ptn_pkg::RGN_HYP_S0: begin
        if (k1_pos) begin
          sel0_nxt = ptn_pkg::SEL_EDGE;
          tm_nxt   = ptn_pkg::MODE_COMP;
        end else begin
          sel1_nxt = ce_le0 ? ptn_pkg::SEL_ONE : ptn_pkg::SEL_AXIS;
        end
      end
      ptn_pkg::RGN_S0: begin
        sel1_nxt = ptn_pkg::SEL_AXIS;
      end
      ptn_pkg::RGN_CORNER0: begin
        if (d_neg) begin
          sel0_nxt = ptn_pkg::SEL_AXIS;
        end else begin
          sel1_nxt = ptn_pkg::SEL_AXIS;
        end
      end
      ptn_pkg::RGN_T0: begin
        sel0_nxt = ptn_pkg::SEL_AXIS;
      end
      ptn_pkg::RGN_HYP_T0: begin
        if (k3_pos) begin
          sel1_nxt = ptn_pkg::SEL_EDGE;
          sm_nxt   = ptn_pkg::MODE_COMP;
        end else begin
          sel0_nxt = ad_le0 ? ptn_pkg::SEL_ONE : ptn_pkg::SEL_AXIS;
        end
      end
      default: begin
        // degenerate triangle: fall back to a single edge
        if (a_zero) begin
          sel1_nxt = ptn_pkg::SEL_AXIS;
        end else if (c_zero) begin
          sel0_nxt = ptn_pkg::SEL_AXIS;
        end else if (b_pos) begin
          if (agc_6) begin
            sel0_nxt = ptn_pkg::SEL_AXIS;
          end else begin
            sel1_nxt = ptn_pkg::SEL_AXIS;
          end
        end else begin
          sel0_nxt = ptn_pkg::SEL_EDGE;
          tm_nxt   = ptn_pkg::MODE_COMP;
        end
      end
    endcase
  end

  logic signed [NW-1:0] det7_r, sn7_r, tn7_r;
  logic signed [KW-1:0] k1_7_r, k2_7_r, k3_7_r, nd7_r, ne7_r;
  logic signed [DW-1:0] a7_r, c7_r;

  // stage 8: divider operands
  logic signed [NW-1:0] num0_r, den0_r, num1_r, den1_r;
  logic signed [NW-1:0] num0_nxt, den0_nxt, num1_nxt, den1_nxt;

  always_comb begin
    case (sel0_r)
      ptn_pkg::SEL_ONE:  begin num0_nxt = NW'(1);      den0_nxt = NW'(1);      end
      ptn_pkg::SEL_TRI:  begin num0_nxt = sn7_r;       den0_nxt = det7_r;      end
      ptn_pkg::SEL_EDGE: begin num0_nxt = NW'(k1_7_r); den0_nxt = NW'(k2_7_r); end
      ptn_pkg::SEL_AXIS: begin num0_nxt = NW'(nd7_r);  den0_nxt = NW'(a7_r);   end
      default:           begin num0_nxt = '0;          den0_nxt = NW'(1);      end
    endcase
    case (sel1_r)
      ptn_pkg::SEL_ONE:  begin num1_nxt = NW'(1);      den1_nxt = NW'(1);      end
      ptn_pkg::SEL_TRI:  begin num1_nxt = tn7_r;       den1_nxt = det7_r;      end
      ptn_pkg::SEL_EDGE: begin num1_nxt = NW'(k3_7_r); den1_nxt = NW'(k2_7_r); end
      ptn_pkg::SEL_AXIS: begin num1_nxt = NW'(ne7_r);  den1_nxt = NW'(c7_r);   end
      default:           begin num1_nxt = '0;          den1_nxt = NW'(1);      end
    endcase
  end

  // stages 9 to FB+9: the two clamped quotients
  logic [WW-1:0] q0, q1;

  ptn_div #(.NW(NW), .FB(FB)) u_div0 (.clk, .en(adv), .num(num0_r), .den(den0_r), .q(q0));
  ptn_div #(.NW(NW), .FB(FB)) u_div1 (.clk, .en(adv), .num(num1_r), .den(den1_r), .q(q1));

  logic [1:0] mode_d;

  ptn_dly #(.W(2), .N(FB + 2)) u_dly_mode (
    .clk, .en(adv), .d({sm_r, tm_r}), .q(mode_d)
  );

  // dot products ride along to the distance stages
  logic signed [DW-1:0] a10, b10, c10, d10, e10, f10;
  logic signed [DW-1:0] a11, b11, c11, f14;
  logic [3*DW-1:0]      abc11_out;

  ptn_dly #(.W(APW), .N(FB + 4)) u_dly_dot1 (
    .clk, .en(adv), .d(abc6_out), .q(abc10_out)
  );
  assign {a10, b10, c10, d10, e10, f10} = abc10_out;

  ptn_dly #(.W(3 * DW), .N(1)) u_dly_abc (
    .clk, .en(adv), .d({a10, b10, c10}), .q(abc11_out)
  );
  assign {a11, b11, c11} = abc11_out;

  ptn_dly #(.W(DW), .N(4)) u_dly_f (.clk, .en(adv), .d(f10), .q(f14));

  // region code follows the beat to the output
  ptn_dly #(.W(ptn_pkg::REGION_W), .N(FB + 9)) u_dly_region (
    .clk, .en(adv), .d(region_r), .q(out_region_code)
  );

  // D0: final weights
  logic [WW-1:0] s_r, t_r, s_nxt, t_nxt;

  always_comb begin
    s_nxt = (mode_d[1] == ptn_pkg::MODE_COMP) ? WW'(ONE_W - q1) : q0;
    t_nxt = (mode_d[0] == ptn_pkg::MODE_COMP) ? WW'(ONE_W - q0) : q1;
  end

  ptn_dly #(.W(2 * WW), .N(6)) u_dly_st (
    .clk, .en(adv), .d({s_r, t_r}), .q({out_weight_s, out_weight_t})
  );

  // D1: weight products and linear terms
  logic [SQW-1:0]       ss_r, st_r, tt_r, ss_nxt, st_nxt, tt_nxt;
  logic signed [LNW-1:0] ds_r, et_r, ds_nxt, et_nxt;

  always_comb begin
    ss_nxt = s_r * s_r;
    st_nxt = s_r * t_r;
    tt_nxt = t_r * t_r;
    ds_nxt = d10 * $signed({1'b0, s_r});
    et_nxt = e10 * $signed({1'b0, t_r});
  end

  // D2-D3: quadratic terms
  logic signed [MPW-1:0] ass_p, bst_p, ctt_p;

  ptn_mul #(.AW(DW), .BW(SPW)) u_mul_ass (
    .clk, .en(adv), .a(a11), .b($signed({1'b0, ss_r})), .p(ass_p)
  );
  ptn_mul #(.AW(DW), .BW(SPW)) u_mul_bst (
    .clk, .en(adv), .a(b11), .b($signed({1'b0, st_r})), .p(bst_p)
  );
  ptn_mul #(.AW(DW), .BW(SPW)) u_mul_ctt (
    .clk, .en(adv), .a(c11), .b($signed({1'b0, tt_r})), .p(ctt_p)
  );

  logic signed [LSW-1:0] lin2_r, lin3_r, lin2_nxt;
  logic signed [ACW-1:0] sum1_r, sum2_r, acc_r, sum1_nxt, sum2_nxt, acc_nxt;
  logic [HW-1:0]         acc_hi;
  logic [ptn_pkg::DIST_W-1:0] dist_r, dist_nxt;

  always_comb begin
    lin2_nxt = LSW'(ds_r) + LSW'(et_r);
    sum1_nxt = ACW'(ass_p) + (ACW'(bst_p) <<< 1);
    sum2_nxt = ACW'(ctt_p) + (ACW'(lin3_r) <<< (FB + 1));
    acc_nxt  = sum1_r + sum2_r + (ACW'(f14) <<< (2 * FB));
    acc_hi   = acc_r[ACW-1:2*FB];
    // negative form clamps at zero, large form saturates
    if (acc_r[ACW-1]) begin
      dist_nxt = '0;
    end else if (CMPW'(acc_hi) > CMPW'(ptn_pkg::DIST_MAX)) begin
      dist_nxt = ptn_pkg::DIST_MAX;
    end else begin
      dist_nxt = ptn_pkg::DIST_W'(acc_hi);
    end
  end

  assign out_dist_squared = dist_r;

  // payload registers, all frozen together on a stall
  always_ff @(posedge clk) begin
    if (adv) begin
      bp_r     <= bp_nxt;
      e0_r     <= e0_nxt;
      e1_r     <= e1_nxt;
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pc_r     <= pc_nxt;
      pd_r     <= pd_nxt;
      pe_r     <= pe_nxt;
      pf_r     <= pf_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      c_r      <= c_nxt;
      d_r      <= d_nxt;
      e_r      <= e_nxt;
      f_r      <= f_nxt;
      k1_r     <= k1_nxt;
      k2_r     <= k2_nxt;
      k3_r     <= k3_nxt;
      ce_r     <= ce_nxt;
      ad_r     <= ad_nxt;
      nd_r     <= nd_nxt;
      ne_r     <= ne_nxt;
      agc_r    <= agc_nxt;
      det_r    <= det_nxt;
      sn_r     <= sn_nxt;
      tn_r     <= tn_nxt;
      region_r <= region_nxt;
      sel0_r   <= sel0_nxt;
      sel1_r   <= sel1_nxt;
      sm_r     <= sm_nxt;
      tm_r     <= tm_nxt;
      det7_r   <= det_r;
      sn7_r    <= sn_r;
      tn7_r    <= tn_r;
      k1_7_r   <= k1_6;
      k2_7_r   <= k2_6;
      k3_7_r   <= k3_6;
      nd7_r    <= nd_6;
      ne7_r    <= ne_6;
      a7_r     <= a6;
      c7_r     <= c6;
      num0_r   <= num0_nxt;
      den0_r   <= den0_nxt;
      num1_r   <= num1_nxt;
      den1_r   <= den1_nxt;
      s_r      <= s_nxt;
      t_r      <= t_nxt;
      ss_r     <= ss_nxt;
      st_r     <= st_nxt;
      tt_r     <= tt_nxt;
      ds_r     <= ds_nxt;
      et_r     <= et_nxt;
      lin2_r   <= lin2_nxt;
      lin3_r   <= lin2_r;
      sum1_r   <= sum1_nxt;
      sum2_r   <= sum2_nxt;
      acc_r    <= acc_nxt;
      dist_r   <= dist_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptn_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module ptn_chk #(
  parameter int FRAC_BITS = 16
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [FRAC_BITS:0]           out_weight_s,
  input wire logic [FRAC_BITS:0]           out_weight_t,
  input wire logic [ptn_pkg::DIST_W-1:0]   out_dist_squared,
  input wire logic [ptn_pkg::REGION_W-1:0] out_region_code
);

  localparam logic [FRAC_BITS:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS+1:0] wsum;
  assign wsum = {1'b0, out_weight_s} + {1'b0, out_weight_t};

  // a held result beat keeps its payload
  `PTN_ASSERT(a_out_hold, clk, rst_n, ((out_valid && !out_ready) |=> (out_valid && $stable(out_weight_s) && $stable(out_weight_t) && $stable(out_dist_squared) && $stable(out_region_code))), "result beat changed while stalled")
  // an empty output stage never blocks the input
  `PTN_ASSERT_IMP(a_no_block, clk, rst_n, (!out_valid), (in_ready), "input blocked with empty output")
  // weights stay inside the unit interval
  `PTN_ASSERT_IMP(a_w_range, clk, rst_n, (out_valid), ((out_weight_s <= ONE_W) && (out_weight_t <= ONE_W)), "weight above one")
  // beyond the far edge the weights sum to one
  `PTN_ASSERT_IMP(a_hyp_sum, clk, rst_n, (out_valid && (out_region_code == ptn_pkg::RGN_HYP)), (wsum == {1'b0, ONE_W}), "far edge weights do not sum to one")
  // below the s axis the t weight is zero
  `PTN_ASSERT_IMP(a_t0_zero, clk, rst_n, (out_valid && (out_region_code == ptn_pkg::RGN_T0)), (out_weight_t == '0), "t weight nonzero on t edge")

endmodule

bind point_triangle_nearest ptn_chk #(.FRAC_BITS(FRAC_BITS)) u_ptn_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_weight_s(out_weight_s),
  .out_weight_t(out_weight_t),
  .out_dist_squared(out_dist_squared),
  .out_region_code(out_region_code)
);
`default_nettype wire
